### hdl/combined_lcg_shuffle_rng_assert.svh
// assertion macros shared by the generator's modules
`ifndef COMBINED_LCG_SHUFFLE_RNG_ASSERT_SVH
`define COMBINED_LCG_SHUFFLE_RNG_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CLSR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CLSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/clsr_pkg.sv
// package: constants, codes and control types of the combined lcg shuffle generator
package clsr_pkg;

  // default shuffle table depth
  localparam int unsigned CLSR_TABLE_DEPTH = 32;
  // warm-up steps beyond the table depth on a reseed
  localparam int unsigned CLSR_WARM_EXTRA  = 8;

  // generator moduli and multipliers
  localparam logic [30:0] CLSR_MOD_ONE  = 31'd2147483563;
  localparam logic [30:0] CLSR_MOD_TWO  = 31'd2147483399;
  localparam logic [15:0] CLSR_MUL_ONE  = 16'd40014;
  localparam logic [15:0] CLSR_MUL_TWO  = 16'd40692;
  // 2^31 mod modulus, used to fold the high product bits back in
  localparam logic [7:0]  CLSR_FOLD_ONE = 8'd85;
  localparam logic [7:0]  CLSR_FOLD_TWO = 8'd249;
  // output wrap and fraction scaling
  localparam logic [30:0] CLSR_WRAP_TOP = 31'd2147483562;
  localparam logic [7:0]  CLSR_FRAC_K   = 8'd170;
  localparam logic [31:0] CLSR_FRAC_CAP = 32'd4294966780;

  // reset values of the generators
  localparam logic [30:0] CLSR_SEED_ONE = 31'd123456;
  localparam logic [30:0] CLSR_SEED_TWO = 31'd123456789;

  // command codes of an input beat
  localparam logic CLSR_CMD_DRAW   = 1'b0;
  localparam logic CLSR_CMD_RESEED = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic seed_load;
    logic mult;
    logic fold;
    logic warm_step;
    logic draw_step;
    logic tbl_read;
    logic draw_update;
    logic frac_mul;
    logic frac_fold;
    logic out_load;
  } clsr_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic warm_last;
    logic out_free;
  } clsr_sts_t;

endpackage

### hdl/clsr_in_if.sv
// input channel: command and seed beat with valid/ready
interface clsr_in_if
  import clsr_pkg::*;
();
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [30:0] seed_value;

  modport source (output valid, output cmd, output seed_value, input ready);
  modport sink   (input valid, input cmd, input seed_value, output ready);
endinterface

### hdl/clsr_out_if.sv
// result channel: random integer and fraction beat with valid/ready
interface clsr_out_if
  import clsr_pkg::*;
();
  logic        valid;
  logic        ready;
  logic [30:0] rand_int;
  logic [31:0] rand_frac;

  modport source (output valid, output rand_int, output rand_frac, input ready);
  modport sink   (input valid, input rand_int, input rand_frac, output ready);
endinterface

### hdl/clsr_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module clsr_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/clsr_ctrl.sv
// controller: sequences reseed warm-up, draw and fraction steps
`include "combined_lcg_shuffle_rng_assert.svh"
module clsr_ctrl
  import clsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_cmd,
  output logic      in_ready,
  input  clsr_sts_t sts,
  output clsr_cmd_t cmd
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_WMUL  = 11'b000_0000_0010,
    S_WFOLD = 11'b000_0000_0100,
    S_WRED  = 11'b000_0000_1000,
    S_DMUL  = 11'b000_0001_0000,
    S_DFOLD = 11'b000_0010_0000,
    S_DRED  = 11'b000_0100_0000,
    S_DDIFF = 11'b000_1000_0000,
    S_FMUL  = 11'b001_0000_0000,
    S_FFOLD = 11'b010_0000_0000,
    S_FOUT  = 11'b100_0000_0000
  } clsr_state_t;

  clsr_state_t state_r;
  clsr_state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CLSR_CMD_RESEED) begin
            cmd.seed_load = 1'b1;
            state_nxt     = S_WMUL;
          end else begin
            state_nxt     = S_DMUL;
          end
        end
      end
      S_WMUL: begin
        cmd.mult  = 1'b1;
        state_nxt = S_WFOLD;
      end
      S_WFOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = S_WRED;
      end
      S_WRED: begin
        cmd.warm_step = 1'b1;
        state_nxt     = sts.warm_last ? S_DMUL : S_WMUL;
      end
      S_DMUL: begin
        cmd.mult  = 1'b1;
        state_nxt = S_DFOLD;
      end
      S_DFOLD: begin
        cmd.fold     = 1'b1;
        cmd.tbl_read = 1'b1;
        state_nxt    = S_DRED;
      end
      S_DRED: begin
        cmd.draw_step = 1'b1;
        state_nxt     = S_DDIFF;
      end
      S_DDIFF: begin
        cmd.draw_update = 1'b1;
        state_nxt       = S_FMUL;
      end
      S_FMUL: begin
        cmd.frac_mul = 1'b1;
        state_nxt    = S_FFOLD;
      end
      S_FFOLD: begin
        cmd.frac_fold = 1'b1;
        state_nxt     = S_FOUT;
      end
      S_FOUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // a result is only loaded when the output register can take it
  `CLSR_ASSERT_SAME(a_load_when_free, cmd.out_load, sts.out_free, "result loaded over a held beat")
  // a reseed beat always starts the warm-up
  `CLSR_ASSERT_NEXT(a_reseed_warm, in_valid && in_ready && in_cmd == CLSR_CMD_RESEED, state_r == S_WMUL, "reseed did not enter warm-up")

endmodule

### hdl/clsr_dp.sv
// datapath: generator registers, modular multiply, shuffle table and fraction
`include "combined_lcg_shuffle_rng_assert.svh"
module clsr_dp
  import clsr_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = CLSR_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [30:0] in_seed_value,
  input  clsr_cmd_t   cmd,
  output clsr_sts_t   sts,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [30:0] out_rand_int,
  output logic [31:0] out_rand_frac
);

  localparam int unsigned SLOT_W   = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W    = $clog2(TABLE_DEPTH + CLSR_WARM_EXTRA);
  localparam int unsigned SLOT_DIV = 1 + (int'(CLSR_WRAP_TOP) / TABLE_DEPTH);

  // generator state
  logic [30:0]       gen_one_r;
  logic [30:0]       gen_two_r;
  logic [30:0]       last_output_r;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] slot_nxt;
  logic [CNT_W-1:0]  warm_cnt_r;

  // modular multiply pipeline
  logic [46:0] prod_one_r;
  logic [46:0] prod_two_r;
  logic [31:0] fold_one_r;
  logic [31:0] fold_two_r;
  logic [30:0] red_one;
  logic [30:0] red_two;
  logic [30:0] seed_eff;

  // shuffle table
  logic [TABLE_DEPTH-1:0] tbl_valid_r;
  logic                   tbl_hit_r;
  logic                   tbl_wr_en;
  logic [SLOT_W-1:0]      tbl_wr_addr;
  logic [30:0]            tbl_wr_data;
  logic [30:0]            tbl_rd_data;
  logic [30:0]            tbl_val;
  logic                   warm_in_table;

  // draw difference and fraction
  logic [31:0] diff;
  logic [30:0] wrapped;
  logic [38:0] frac_t_r;
  logic [7:0]  frac_hi_r;
  logic [31:0] frac_s_r;
  logic [32:0] frac_q;
  logic [31:0] frac_capped;

  // output register
  logic        out_valid_r;
  logic [30:0] out_rand_int_r;
  logic [31:0] out_rand_frac_r;

  // zero seed becomes one
  assign seed_eff = (in_seed_value == '0) ? 31'd1 : in_seed_value;

  // reduce a folded value below the modulus with one subtract
  assign red_one = (fold_one_r >= {1'b0, CLSR_MOD_ONE}) ?
                   31'(fold_one_r - {1'b0, CLSR_MOD_ONE}) : fold_one_r[30:0];
  assign red_two = (fold_two_r >= {1'b0, CLSR_MOD_TWO}) ?
                   31'(fold_two_r - {1'b0, CLSR_MOD_TWO}) : fold_two_r[30:0];

  // slot from last output: count of slot boundaries at or below it
  always_comb begin
    slot_nxt = '0;
    for (int k = 1; k < int'(TABLE_DEPTH); k++) begin
      if ({1'b0, last_output_r} >= 32'(k * SLOT_DIV)) begin
        slot_nxt = SLOT_W'(k);
      end
    end
  end

  // table write: warm-up fill or refill of the drawn slot
  assign warm_in_table = (warm_cnt_r < CNT_W'(TABLE_DEPTH));
  assign tbl_wr_en     = (cmd.warm_step && warm_in_table) || cmd.draw_update;
  assign tbl_wr_addr   = cmd.draw_update ? slot_r : warm_cnt_r[SLOT_W-1:0];
  assign tbl_wr_data   = cmd.draw_update ? gen_one_r : red_one;

  clsr_ram #(
    .WIDTH (31),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_en   (cmd.tbl_read),
    .rd_addr (slot_r),
    .rd_data (tbl_rd_data)
  );

  // an entry never written reads as zero
  assign tbl_val = tbl_hit_r ? tbl_rd_data : '0;

  // slot value minus generator two, wrapped into 1..wrap top
  assign diff    = {1'b0, tbl_val} - {1'b0, gen_two_r};
  assign wrapped = (diff[31] || diff == '0) ?
                   31'(diff + {1'b0, CLSR_WRAP_TOP}) : diff[30:0];

  // fraction: floor(l * 2^32 / m1) = 2l + hi + (s >= m1)
  assign frac_q      = {1'b0, last_output_r, 1'b0} + 33'(frac_hi_r)
                     + 33'(frac_s_r >= {1'b0, CLSR_MOD_ONE});
  assign frac_capped = (frac_q > {1'b0, CLSR_FRAC_CAP}) ? CLSR_FRAC_CAP : frac_q[31:0];

  // generator and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_one_r     <= CLSR_SEED_ONE;
      gen_two_r     <= CLSR_SEED_TWO;
      last_output_r <= '0;
      warm_cnt_r    <= '0;
      tbl_valid_r   <= '0;
      tbl_hit_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.seed_load) begin
        gen_one_r  <= seed_eff;
        gen_two_r  <= seed_eff;
        warm_cnt_r <= CNT_W'(TABLE_DEPTH + CLSR_WARM_EXTRA - 1);
      end
      if (cmd.warm_step) begin
        gen_one_r <= red_one;
        if (warm_cnt_r == '0) begin
          last_output_r <= red_one;
        end else begin
          warm_cnt_r <= warm_cnt_r - 1'b1;
        end
      end
      if (cmd.draw_step) begin
        gen_one_r <= red_one;
        gen_two_r <= red_two;
      end
      if (cmd.draw_update) begin
        last_output_r <= wrapped;
      end
      if (tbl_wr_en) begin
        tbl_valid_r[tbl_wr_addr] <= 1'b1;
      end
      if (cmd.tbl_read) begin
        tbl_hit_r <= tbl_valid_r[slot_r];
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // pipeline payload registers
  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      prod_one_r <= 47'(CLSR_MUL_ONE) * 47'(gen_one_r);
      prod_two_r <= 47'(CLSR_MUL_TWO) * 47'(gen_two_r);
      slot_r     <= slot_nxt;
    end
    if (cmd.fold) begin
      fold_one_r <= 32'(prod_one_r[46:31]) * 32'(CLSR_FOLD_ONE) + 32'(prod_one_r[30:0]);
      fold_two_r <= 32'(prod_two_r[46:31]) * 32'(CLSR_FOLD_TWO) + 32'(prod_two_r[30:0]);
    end
    if (cmd.frac_mul) begin
      frac_t_r <= 39'(last_output_r) * 39'(CLSR_FRAC_K);
    end
    if (cmd.frac_fold) begin
      frac_hi_r <= frac_t_r[38:31];
      frac_s_r  <= 32'(frac_t_r[38:31]) * 32'(CLSR_FOLD_ONE) + 32'(frac_t_r[30:0]);
    end
    if (cmd.out_load) begin
      out_rand_int_r  <= last_output_r;
      out_rand_frac_r <= frac_capped;
    end
  end

  assign sts.warm_last = (warm_cnt_r == '0);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_rand_int  = out_rand_int_r;
  assign out_rand_frac = out_rand_frac_r;

  // a generator step always lands below its modulus
  `CLSR_ASSERT_NEXT(a_gen_one_range, cmd.warm_step || cmd.draw_step, gen_one_r < CLSR_MOD_ONE, "generator one out of range")
  `CLSR_ASSERT_NEXT(a_gen_two_range, cmd.draw_step, gen_two_r < CLSR_MOD_TWO, "generator two out of range")
  // a drawn output is always in 1..wrap top
  `CLSR_ASSERT_NEXT(a_draw_range, cmd.draw_update, last_output_r != '0 && last_output_r <= CLSR_WRAP_TOP, "drawn output out of range")

endmodule

### hdl/combined_lcg_shuffle_rng.sv
// top level: combined lcg random generator with shuffle table
// Combined two-modulus multiplicative generator (moduli 2147483563 and 2147483399)
// behind a TABLE_DEPTH-entry shuffle table. A draw beat (cmd 0) returns one result
// beat after the multiply, fold and reduce steps of the two generators, the table
// difference step and the U0.32 fraction steps, the last of which waits while the
// output register still holds an untaken beat. A reseed beat (cmd 1) first runs
// TABLE_DEPTH+8 warm-up steps of generator one through the same multiply, fold and
// reduce path, then draws. The input is taken only while no item is in progress; a
// finished result waits in the output register without holding up that acceptance.
module combined_lcg_shuffle_rng
  import clsr_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = CLSR_TABLE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  clsr_in_if.sink   in_ch,
  clsr_out_if.source out_ch
);

  clsr_cmd_t cmd;
  clsr_sts_t sts;

  // sequencer
  clsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic, table and output register
  clsr_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_seed_value (in_ch.seed_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_rand_int  (out_ch.rand_int),
    .out_rand_frac (out_ch.rand_frac)
  );

endmodule
